// ===== rtl/core/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared widths and register codes of the linear step distributor.
// ----------------------------------------------------------------------------
package lsd_pkg;

	localparam int DIST_W         = 16;
	localparam int STEP_W         = 16;
	localparam int FRAME_W        = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam int S_DATA_W   = 8;
	localparam int M_DATA_W   = 32;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_DISTANCE_X = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DISTANCE_Y = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_COUNT = 2'd2;

endpackage

// ===== rtl/core/linear_step_distributor.sv =====
// ----------------------------------------------------------------------------
// linear_step_distributor
// Spreads a configured x/y distance over a configured number of frames. Each
// tick transaction with tick set gives one result: the per-axis delta for the
// current frame, with m_tlast on the final frame, after which the frame
// counter wraps. An item passes from acceptance to a loaded result through
// the bit-serial restoring dividers (one per axis, run side by side), then,
// for a frame within the count, a walk down the pattern levels, a base step
// and a walk back up, and last the load of the output register. One item is
// in work at a time; the output register lets the next tick be taken while a
// result waits. A tick transaction with tick clear is taken and gives no
// result. Registers sit at byte addresses 0 (distance_x), 4 (distance_y) and
// 8 (step_count); a step count that is zero in its low COUNT_BITS bits acts
// as one.
// ----------------------------------------------------------------------------
module linear_step_distributor #(
	parameter int COUNT_BITS = lsd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// stream in
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lsd_pkg::S_DATA_W-1:0]    s_tdata,  // [0] tick, rest zero
	// stream out
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lsd_pkg::M_DATA_W-1:0]    m_tdata,  // [15:0] delta_x, [31:16] delta_y
	output logic                            m_tlast,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lsd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lsd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lsd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);

	localparam int DW = lsd_pkg::DIST_W;
	localparam int FW = lsd_pkg::FRAME_W;
	localparam int SW = (COUNT_BITS < lsd_pkg::STEP_W) ? COUNT_BITS : lsd_pkg::STEP_W;
	localparam int LW = $clog2(SW);
	localparam int CW = $clog2(DW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_DOWN,
		ST_BASE,
		ST_UP,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [DW-1:0]                 distance_x_q;
	logic [DW-1:0]                 distance_y_q;
	logic [lsd_pkg::STEP_W-1:0]    step_count_q;
	logic [FW-1:0]                 frame_q;

	logic [CW-1:0]                 cnt_q;
	logic [LW-1:0]                 lvl_q;
	logic                          m_tvalid_q;
	logic [lsd_pkg::M_DATA_W-1:0]  m_tdata_q;
	logic                          m_tlast_q;

	// datapath
	logic [SW-1:0]  t_q;
	logic [SW-1:0]  f_q;
	logic           inr_q;
	logic           lastf_q;
	logic [DW-1:0]  qx_q, qy_q;
	logic [SW-1:0]  rx_q, ry_q;
	logic           negx_q, negy_q;
	logic           bx_q, by_q;
	logic [SW-1:0]  zx_q, zy_q;
	logic [SW-1:0]  tl_stk_q, xl_stk_q, yl_stk_q, mid_stk_q, hi_stk_q;

	logic [SW-1:0]  sc_c, steps_c;
	logic           last_c, inr_c;
	logic [DW-1:0]  mag_x_c, mag_y_c;
	logic [SW:0]    rsh_x_c, rsh_y_c;
	logic           ge_x_c, ge_y_c;
	logic [SW:0]    rdf_x_c, rdf_y_c;
	logic [SW-1:0]  rx_n_c, ry_n_c;
	logic [SW-1:0]  h_c, f_nx_c;
	logic           mid_c, hi_c;
	logic [SW:0]    up_x_c, up_y_c;
	logic [DW-1:0]  delta_x_c, delta_y_c;

	// one level of the pattern on the way up: {bit, zeros before f}
	function automatic logic [SW:0] lvl_step(
		input logic [SW-1:0] t_hi,
		input logic [SW-1:0] d_hi,
		input logic          t_odd,
		input logic          d_odd,
		input logic          at_mid,
		input logic          at_hi,
		input logic          b_lo,
		input logic [SW-1:0] z_lo
	);
		logic [SW-1:0] ztot;
		logic [SW-1:0] zc;
		logic [SW-1:0] z;
		logic          b;
		ztot = t_hi - d_hi;
		zc   = at_hi ? ztot + z_lo : z_lo;
		b    = b_lo;
		z    = zc;
		if (t_odd) begin
			if (at_mid) begin
				b = d_odd;
				z = ztot;
			end else if (at_hi) begin
				z = ztot + SW'(!d_odd) + z_lo;
			end
		end else if (d_odd) begin
			// first zero of the doubled half is set
			b = b_lo | (zc == '0);
			z = (zc == '0) ? zc : zc - SW'(1);
		end
		return {b, z};
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign pready   = 1'b1;

	always_comb begin
		sc_c    = step_count_q[SW-1:0];
		steps_c = (sc_c == '0) ? SW'(1) : sc_c;
		last_c  = frame_q >= FW'(steps_c) - FW'(1);
		inr_c   = frame_q < FW'(steps_c);
		mag_x_c = distance_x_q[DW-1] ? -distance_x_q : distance_x_q;
		mag_y_c = distance_y_q[DW-1] ? -distance_y_q : distance_y_q;

		// restoring division, one quotient bit per cycle
		rsh_x_c = {rx_q, qx_q[DW-1]};
		rsh_y_c = {ry_q, qy_q[DW-1]};
		rdf_x_c = rsh_x_c - {1'b0, t_q};
		rdf_y_c = rsh_y_c - {1'b0, t_q};
		ge_x_c  = rsh_x_c >= {1'b0, t_q};
		ge_y_c  = rsh_y_c >= {1'b0, t_q};
		rx_n_c  = ge_x_c ? rdf_x_c[SW-1:0] : rsh_x_c[SW-1:0];
		ry_n_c  = ge_y_c ? rdf_y_c[SW-1:0] : rsh_y_c[SW-1:0];

		// descent: locate the frame in the left half, middle bit or right half
		h_c = t_q >> 1;
		if (t_q[0]) begin
			mid_c = (f_q == h_c);
			hi_c  = (f_q > h_c);
			if (hi_c) begin
				f_nx_c = f_q - h_c - SW'(1);
			end else if (mid_c) begin
				f_nx_c = '0;
			end else begin
				f_nx_c = f_q;
			end
		end else begin
			mid_c  = 1'b0;
			hi_c   = (f_q >= h_c);
			f_nx_c = hi_c ? f_q - h_c : f_q;
		end

		up_x_c = lvl_step(t_q, rx_q, tl_stk_q[0], xl_stk_q[0], mid_stk_q[0],
			hi_stk_q[0], bx_q, zx_q);
		up_y_c = lvl_step(t_q, ry_q, tl_stk_q[0], yl_stk_q[0], mid_stk_q[0],
			hi_stk_q[0], by_q, zy_q);

		// -(q + b) is ~q + !b
		delta_x_c = negx_q ? ~qx_q + DW'(!bx_q) : qx_q + DW'(bx_q);
		delta_y_c = negy_q ? ~qy_q + DW'(!by_q) : qy_q + DW'(by_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_x_q <= '0;
			distance_y_q <= '0;
			step_count_q <= lsd_pkg::STEP_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				lsd_pkg::REG_DISTANCE_X: distance_x_q <= pwdata[DW-1:0];
				lsd_pkg::REG_DISTANCE_Y: distance_y_q <= pwdata[DW-1:0];
				lsd_pkg::REG_STEP_COUNT: step_count_q <= pwdata[lsd_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			lsd_pkg::REG_DISTANCE_X: prdata = lsd_pkg::APB_DATA_W'(distance_x_q);
			lsd_pkg::REG_DISTANCE_Y: prdata = lsd_pkg::APB_DATA_W'(distance_y_q);
			lsd_pkg::REG_STEP_COUNT: prdata = lsd_pkg::APB_DATA_W'(step_count_q);
			default:                 prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			frame_q    <= '0;
			cnt_q      <= '0;
			lvl_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// in ST_FIN the output register is reloaded instead
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tdata[0]) begin
						frame_q <= last_c ? '0 : frame_q + FW'(1);
						cnt_q   <= '0;
						lvl_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW - 1)) begin
						if (!inr_q) begin
							state_q <= ST_FIN;
						end else if (t_q == SW'(1)) begin
							state_q <= ST_BASE;
						end else begin
							state_q <= ST_DOWN;
						end
					end
				end
				ST_DOWN: begin
					lvl_q <= lvl_q + LW'(1);
					if (h_c == SW'(1)) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= (lvl_q == '0) ? ST_FIN : ST_UP;
				end
				ST_UP: begin
					lvl_q <= lvl_q - LW'(1);
					if (lvl_q == LW'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {delta_y_c, delta_x_c};
						m_tlast_q  <= lastf_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q     <= steps_c;
				f_q     <= frame_q[SW-1:0];
				inr_q   <= inr_c;
				lastf_q <= last_c;
				qx_q    <= mag_x_c;
				qy_q    <= mag_y_c;
				rx_q    <= '0;
				ry_q    <= '0;
				negx_q  <= distance_x_q[DW-1];
				negy_q  <= distance_y_q[DW-1];
				bx_q    <= 1'b0;
				by_q    <= 1'b0;
			end
			ST_DIV: begin
				qx_q <= {qx_q[DW-2:0], ge_x_c};
				qy_q <= {qy_q[DW-2:0], ge_y_c};
				rx_q <= rx_n_c;
				ry_q <= ry_n_c;
			end
			ST_DOWN: begin
				// push the bits dropped by halving, restored on the way up
				tl_stk_q  <= {tl_stk_q[SW-2:0], t_q[0]};
				xl_stk_q  <= {xl_stk_q[SW-2:0], rx_q[0]};
				yl_stk_q  <= {yl_stk_q[SW-2:0], ry_q[0]};
				mid_stk_q <= {mid_stk_q[SW-2:0], mid_c};
				hi_stk_q  <= {hi_stk_q[SW-2:0], hi_c};
				t_q       <= h_c;
				rx_q      <= rx_q >> 1;
				ry_q      <= ry_q >> 1;
				f_q       <= f_nx_c;
			end
			ST_BASE: begin
				bx_q <= rx_q[0];
				by_q <= ry_q[0];
				zx_q <= '0;
				zy_q <= '0;
			end
			ST_UP: begin
				{bx_q, zx_q} <= up_x_c;
				{by_q, zy_q} <= up_y_c;
				t_q          <= {t_q[SW-2:0], tl_stk_q[0]};
				rx_q         <= {rx_q[SW-2:0], xl_stk_q[0]};
				ry_q         <= {ry_q[SW-2:0], yl_stk_q[0]};
				tl_stk_q     <= tl_stk_q >> 1;
				xl_stk_q     <= xl_stk_q >> 1;
				yl_stk_q     <= yl_stk_q >> 1;
				mid_stk_q    <= mid_stk_q >> 1;
				hi_stk_q     <= hi_stk_q >> 1;
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_down_frame_in_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOWN) |-> (f_q < t_q))
		else $error("frame position outside its pattern level");

	a_up_rem_fits_level: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP) |-> (rx_q <= t_q && ry_q <= t_q))
		else $error("remainder level exceeds step level");

	a_up_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP) |-> (lvl_q != '0))
		else $error("ascent with empty level stack");
`endif

endmodule

// ===== dv/tb_linear_step_distributor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_step_distributor
// Self-checking bench for the linear step distributor. Tick transactions go
// in on the slave stream and the registers are set over the APB port while
// the block is idle. A predictor in the bench works out the per-axis delta
// and the last-frame flag of every tick, and each output transaction is
// checked against the oldest prediction. Directed cases cover the reset
// state, extreme distances and counts, a zero count and a count lowered below
// the running frame. Random segments then run under four idling phases.
// ----------------------------------------------------------------------------
module tb_linear_step_distributor;

	import lsd_pkg::*;

	localparam int          SETTLE_CYCLES = 64;
	localparam int          STALL_LIMIT   = 4000;
	localparam int          RANDOM_ITEMS  = 1000;
	localparam int          ZERO_SLOTS    = 40;
	localparam int          LEVEL_SLOTS   = 34;
	localparam int unsigned COUNT_MASK    = 32'((64'd1 << COUNT_BITS_DEF) - 64'd1);

	typedef struct packed {
		logic [DIST_W-1:0] dx;
		logic [DIST_W-1:0] dy;
		logic              last;
	} frame_move_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// mirror of the block's registers and frame counter
	logic [DIST_W-1:0]  dist_x_mirror;
	logic [DIST_W-1:0]  dist_y_mirror;
	logic [STEP_W-1:0]  steps_mirror;
	logic [FRAME_W-1:0] frame_mirror;

	frame_move_t pending_moves[$];

	int send_idle_pct;
	int recv_stall_pct;
	int fail_count;
	int ticks_taken;
	int results_seen;
	int reg_writes;
	int random_items;
	int quiet_cycles;

	linear_step_distributor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// bit f of the spread pattern for remainder d over t frames
	function automatic bit spread_bit(int unsigned d, int unsigned t, int unsigned f);
		int unsigned lvl_t[LEVEL_SLOTS];
		int unsigned lvl_d[LEVEL_SLOTS];
		int unsigned fill_pos[LEVEL_SLOTS];
		bit          fill_en[LEVEL_SLOTS];
		int unsigned zeros_in[ZERO_SLOTS];
		int unsigned zeros_out[ZERO_SLOTS];
		int          n_in;
		int          n_out;
		int          depth;
		int          k;
		int          i;
		int unsigned half;
		bit          odd;
		n_in  = 0;
		depth = 0;
		lvl_t[0] = t;
		lvl_d[0] = d;
		while (lvl_t[depth] > 1 && depth < LEVEL_SLOTS - 1) begin
			lvl_t[depth+1] = lvl_t[depth] / 2;
			lvl_d[depth+1] = lvl_d[depth] / 2;
			depth++;
		end
		if (lvl_d[depth] == 0) begin
			zeros_in[0] = 0;
			n_in = 1;
		end
		fill_en[depth]  = 1'b0;
		fill_pos[depth] = 0;
		// walk back up, keeping the lowest zero positions of each level
		for (k = depth - 1; k >= 0; k--) begin
			half  = lvl_t[k+1];
			odd   = lvl_t[k][0];
			n_out = 0;
			for (i = 0; i < n_in && n_out < ZERO_SLOTS; i++) begin
				zeros_out[n_out] = zeros_in[i];
				n_out++;
			end
			if (odd && !lvl_d[k][0] && n_out < ZERO_SLOTS) begin
				zeros_out[n_out] = half;
				n_out++;
			end
			for (i = 0; i < n_in && n_out < ZERO_SLOTS; i++) begin
				zeros_out[n_out] = zeros_in[i] + half + (odd ? 1 : 0);
				n_out++;
			end
			fill_en[k]  = 1'b0;
			fill_pos[k] = 0;
			if (!odd && lvl_d[k][0] && n_out > 0) begin
				fill_en[k]  = 1'b1;
				fill_pos[k] = zeros_out[0];
				for (i = 0; i < n_out - 1; i++)
					zeros_out[i] = zeros_out[i+1];
				n_out--;
			end
			for (i = 0; i < n_out; i++)
				zeros_in[i] = zeros_out[i];
			n_in = n_out;
		end
		if (f >= t)
			return 1'b0;
		for (k = 0; k <= depth; k++) begin
			if (lvl_t[k] == 1)
				return lvl_d[k] != 0;
			if (fill_en[k] && f == fill_pos[k])
				return 1'b1;
			half = lvl_t[k+1];
			if (lvl_t[k][0]) begin
				if (f == half)
					return lvl_d[k][0];
				if (f > half)
					f -= half + 1;
			end else if (f >= half) begin
				f -= half;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [DIST_W-1:0] axis_move(logic [DIST_W-1:0] dist_raw,
			int unsigned steps, int unsigned frame);
		int          dist_val;
		int          quot;
		int unsigned mag;
		dist_val = int'($signed(dist_raw));
		mag      = (dist_val < 0) ? -dist_val : dist_val;
		quot     = dist_val / int'(steps);
		if (spread_bit(mag % steps, steps, frame))
			quot += (dist_val < 0) ? -1 : ((dist_val > 0) ? 1 : 0);
		return quot[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			return $urandom_range(1) ? 16'h7FFF : 16'h8000;
		else if (r < 50)
			return 16'(int'($urandom_range(40)) - 20);
		return 16'($urandom);
	endfunction

	// predictor, scoreboard and stall watchdog
	always @(posedge clk) begin : monitor_b
		bit          active;
		int unsigned steps;
		frame_move_t mv;
		frame_move_t got;
		if (arst_n) begin
			active = 1'b0;
			if (psel && penable && pready) begin
				active = 1'b1;
				if (pwrite) begin
					reg_writes++;
					case (paddr[APB_ADDR_W-1:2])
						REG_DISTANCE_X: dist_x_mirror = pwdata[DIST_W-1:0];
						REG_DISTANCE_Y: dist_y_mirror = pwdata[DIST_W-1:0];
						REG_STEP_COUNT: steps_mirror  = pwdata[STEP_W-1:0];
						default: ;
					endcase
				end
			end
			if (m_tvalid && m_tready) begin
				active = 1'b1;
				results_seen++;
				got.dx   = m_tdata[15:0];
				got.dy   = m_tdata[31:16];
				got.last = m_tlast;
				if (pending_moves.size() == 0) begin
					$error("unexpected result transaction: delta_x %0d delta_y %0d last_frame %0b",
						$signed(got.dx), $signed(got.dy), got.last);
					fail_count++;
				end else begin
					mv = pending_moves.pop_front();
					if (got.dx !== mv.dx) begin
						$error("delta_x: expected %0d, got %0d", $signed(mv.dx), $signed(got.dx));
						fail_count++;
					end
					if (got.dy !== mv.dy) begin
						$error("delta_y: expected %0d, got %0d", $signed(mv.dy), $signed(got.dy));
						fail_count++;
					end
					if (got.last !== mv.last) begin
						$error("last_frame: expected %0b, got %0b", mv.last, got.last);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				active = 1'b1;
				if (s_tdata[0]) begin
					ticks_taken++;
					steps = steps_mirror & COUNT_MASK;
					if (steps == 0)
						steps = 1;
					mv.dx   = axis_move(dist_x_mirror, steps, frame_mirror);
					mv.dy   = axis_move(dist_y_mirror, steps, frame_mirror);
					mv.last = (frame_mirror >= steps - 1);
					frame_mirror = mv.last ? '0 : frame_mirror + 1'b1;
					pending_moves = {pending_moves, mv};
				end
			end
			quiet_cycles = active ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("stalled for %0d cycles with %0d results outstanding",
					quiet_cycles, pending_moves.size());
				$display("tb_linear_step_distributor: FAIL");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_item(input bit tick_val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DATA_W-1){1'b0}}, tick_val};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain_moves();
		s_tvalid <= 1'b0;
		while (pending_moves.size() != 0)
			@(negedge clk);
		// tick-low transactions give no result; idle before the next register writes
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input bit wr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_checked(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
		logic [APB_DATA_W-1:0] rdata;
		apb_access(idx, 1'b1, APB_DATA_W'(value), rdata);
		apb_access(idx, 1'b0, '0, rdata);
		if (rdata[15:0] !== value) begin
			$error("register %0d readback: expected 0x%04h, got 0x%04h", idx, value, rdata[15:0]);
			fail_count++;
		end
	endtask

	task automatic set_movement(input logic [15:0] dx, input logic [15:0] dy,
			input logic [15:0] steps);
		write_checked(REG_DISTANCE_X, dx);
		write_checked(REG_DISTANCE_Y, dy);
		write_checked(REG_STEP_COUNT, steps);
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(1'b1);
	endtask

	task automatic test_reset_state();
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		drain_moves();
	endtask

	task automatic test_extreme_distances();
		set_movement(16'h7FFF, 16'h8000, 16'd1);
		send_ticks(2);
		drain_moves();
		set_movement(16'h8000, 16'h7FFF, 16'hFFFF);
		send_ticks(3);
		drain_moves();
	endtask

	task automatic test_count_corners();
		// zero count acts as one, and the frame left running above is past it
		set_movement(16'd100, -16'sd100, 16'd0);
		send_item(1'b1);
		drain_moves();
		set_movement(-16'sd7, 16'd5, 16'd3);
		send_ticks(3);
		drain_moves();
		// even count with odd remainder
		set_movement(16'd3, -16'sd1, 16'd2);
		send_ticks(2);
		drain_moves();
		// count lowered below the running frame
		set_movement(16'd50, -16'sd50, 16'd8);
		send_ticks(3);
		drain_moves();
		write_checked(REG_STEP_COUNT, 16'd2);
		send_item(1'b0);
		send_item(1'b1);
		drain_moves();
	endtask

	task automatic run_random_segment(input int phase);
		int          r;
		int          n;
		int          sent;
		logic [15:0] steps;
		case (phase)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
		r = $urandom_range(99);
		if (r < 60)
			steps = 16'($urandom_range(12, 1));
		else if (r < 85)
			steps = 16'($urandom_range(200, 13));
		else if (r < 92)
			steps = 16'd0;
		else if (r < 96)
			steps = 16'hFFFF;
		else
			steps = 16'($urandom_range(65535, 1000));
		set_movement(pick_distance(), pick_distance(), steps);
		n    = $urandom_range(80, 20);
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(9) == 0) begin
				send_item(1'b0);
			end else begin
				send_item(1'b1);
				sent++;
			end
			random_items++;
		end
		drain_moves();
	endtask

	task automatic test_random_phases();
		int seg;
		seg = 0;
		while (random_items < RANDOM_ITEMS) begin
			run_random_segment(seg % 4);
			seg++;
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fail_count     = 0;
		ticks_taken    = 0;
		results_seen   = 0;
		reg_writes     = 0;
		random_items   = 0;
		quiet_cycles   = 0;
		dist_x_mirror  = '0;
		dist_y_mirror  = '0;
		steps_mirror   = 16'd1;
		frame_mirror   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_extreme_distances();
		test_count_corners();
		test_random_phases();

		$display("ran %0d ticks and checked %0d results across %0d register writes,",
			ticks_taken, results_seen, reg_writes);
		$display("with extreme distances and counts under four sender/receiver idling phases");
		if (fail_count == 0)
			$display("tb_linear_step_distributor: PASS");
		else
			$display("tb_linear_step_distributor: FAIL");
		$finish;
	end

endmodule
